[sv/bru_pkg.sv]
`timescale 1ns / 1ps

package bru_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int LEN_W     = 9;
    localparam int BYTE_W    = 8;
    localparam int ACT_W     = 2;
    localparam int CNT_MAX   = 255;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_PULL  = 2'd1,
        ACT_UNGET = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    typedef struct packed {
        logic load_item;
        logic execute;
    } t_dp_cmd;

endpackage

[sv/bru_item_if.sv]
`timescale 1ns / 1ps

interface bru_item_if;
    import bru_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] data_in;
    logic              last_of_request;

    modport source (output valid, action, data_in, last_of_request, input ready);
    modport sink   (input valid, action, data_in, last_of_request, output ready);
endinterface

[sv/bru_result_if.sv]
`timescale 1ns / 1ps

interface bru_result_if;
    import bru_pkg::*;

    logic              valid;
    logic              ready;
    logic              ok;
    logic [BYTE_W-1:0] data_out;
    logic [BYTE_W-1:0] occupancy;
    logic [BYTE_W-1:0] moved_count;

    modport source (output valid, ok, data_out, occupancy, moved_count, input ready);
    modport sink   (input valid, ok, data_out, occupancy, moved_count, output ready);
endinterface

[sv/byte_ring_buffer_with_unget.sv]
`timescale 1ns / 1ps

// Byte ring buffer with push at the tail, pull from the head and unget in
// front of the head. The ring keeps one slot free, so it holds at most
// length - 1 bytes.
// i_item carries one byte operation per beat (action, data_in,
// last_of_request); o_result returns exactly one beat per item with ok,
// data_out, occupancy and the moved count of the current request.
// i_cfg_wr_en / i_cfg_wr_data set the ring length (2..DEPTH, clamped) and
// empty the ring; write it only while no item is in flight.
// Timing: an item is taken in the idle state, executed in the next cycle
// (pointer compare plus a write and a read of the byte store, read data
// registered) and its result is offered from the cycle after that. One
// item is in flight at a time, set by the control sequence around the
// store access.
// If the receiver stalls, the result holds on o_result and i_item.ready
// stays low until the result beat is taken.
// Reset (synchronous, active low) empties the ring, clears the moved count
// and sets the length to 256 (or DEPTH if smaller). Store contents are not
// cleared; only bytes that were written can be read back.

module byte_ring_buffer_with_unget #(
    parameter int DEPTH = bru_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    bru_item_if.sink                  i_item,
    bru_result_if.source              o_result,
    input  logic                      i_cfg_wr_en,
    input  logic [bru_pkg::LEN_W-1:0] i_cfg_wr_data
);
    import bru_pkg::*;

    t_dp_cmd cmd;

    bru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd)
    );

    bru_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_action          (i_item.action),
        .i_data_in         (i_item.data_in),
        .i_last_of_request (i_item.last_of_request),
        .o_ok              (o_result.ok),
        .o_data_out        (o_result.data_out),
        .o_occupancy       (o_result.occupancy),
        .o_moved_count     (o_result.moved_count)
    );

endmodule

[sv/bru_ctrl.sv]
`timescale 1ns / 1ps

module bru_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output bru_pkg::t_dp_cmd o_cmd
);
    import bru_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = (r_state == S_OUT);
    assign o_cmd.load_item = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.execute   = (r_state == S_EXEC);

endmodule

[sv/bru_dp.sv]
`timescale 1ns / 1ps

module bru_dp #(
    parameter int DEPTH = bru_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bru_pkg::t_dp_cmd           i_cmd,
    input  logic                       i_cfg_wr_en,
    input  logic [bru_pkg::LEN_W-1:0]  i_cfg_wr_data,
    input  logic [bru_pkg::ACT_W-1:0]  i_action,
    input  logic [bru_pkg::BYTE_W-1:0] i_data_in,
    input  logic                       i_last_of_request,
    output logic                       o_ok,
    output logic [bru_pkg::BYTE_W-1:0] o_data_out,
    output logic [bru_pkg::BYTE_W-1:0] o_occupancy,
    output logic [bru_pkg::BYTE_W-1:0] o_moved_count
);
    import bru_pkg::*;

    localparam int PTR_W     = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int PW        = PTR_W + 1;
    localparam int CW        = (PW > LEN_W) ? PW : LEN_W;
    localparam int OW        = (PW > BYTE_W + 1) ? PW : BYTE_W + 1;
    localparam int RESET_LEN = (DEPTH < 256) ? DEPTH : 256;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    logic [PW-1:0]     r_len;
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [BYTE_W-1:0] r_req_moved;

    t_action           r_action;
    logic [BYTE_W-1:0] r_data;
    logic              r_last;

    logic              r_ok;
    logic              r_pull;
    logic [BYTE_W-1:0] r_echo;
    logic [BYTE_W-1:0] r_occ;
    logic [BYTE_W-1:0] r_moved_out;

    logic [CW-1:0]     cfg_ext;
    logic [PW-1:0]     n_len;
    logic [PW-1:0]     w;
    logic [PW-1:0]     r;
    logic [PW-1:0]     w_inc;
    logic [PW-1:0]     r_inc;
    logic [PW-1:0]     r_dec;
    logic              push_ok;
    logic              pull_ok;
    logic              unget_ok;
    logic              op_ok;
    logic [PW-1:0]     n_w;
    logic [PW-1:0]     n_r;
    logic [PW-1:0]     occ;
    logic [OW-1:0]     occ_ext;
    logic [BYTE_W-1:0] n_occ;
    logic [BYTE_W-1:0] n_moved;
    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;

    // clamp the written length into 2..DEPTH
    always_comb begin
        cfg_ext = CW'(i_cfg_wr_data);
        if (cfg_ext < CW'(2)) begin
            n_len = PW'(2);
        end else if (cfg_ext > CW'(DEPTH)) begin
            n_len = PW'(DEPTH);
        end else begin
            n_len = cfg_ext[PW-1:0];
        end
    end

    always_comb begin
        w = (PW'(r_wp) >= r_len) ? '0 : PW'(r_wp);
        r = (PW'(r_rp) >= r_len) ? '0 : PW'(r_rp);

        w_inc = (w + PW'(1) == r_len) ? '0 : w + PW'(1);
        r_inc = (r + PW'(1) == r_len) ? '0 : r + PW'(1);
        r_dec = (r == '0) ? r_len - PW'(1) : r - PW'(1);

        push_ok  = (r_action == ACT_PUSH)  && (w_inc != r);
        pull_ok  = (r_action == ACT_PULL)  && (r != w);
        unget_ok = (r_action == ACT_UNGET) && (r_dec != w);
        op_ok    = push_ok || pull_ok || unget_ok;

        n_w = push_ok  ? w_inc : w;
        n_r = pull_ok  ? r_inc : (unget_ok ? r_dec : r);

        occ     = (n_w >= n_r) ? (n_w - n_r) : (r_len - n_r + n_w);
        occ_ext = OW'(occ);
        n_occ   = (occ_ext > OW'(CNT_MAX)) ? BYTE_W'(CNT_MAX) : occ_ext[BYTE_W-1:0];

        n_moved = (op_ok && (r_req_moved != BYTE_W'(CNT_MAX)))
                ? r_req_moved + BYTE_W'(1) : r_req_moved;

        mem_we    = i_cmd.execute && (push_ok || unget_ok);
        mem_waddr = push_ok ? w[PTR_W-1:0] : r_dec[PTR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_data;
        end
        if (i_cmd.execute) begin
            r_rdata <= r_mem[r[PTR_W-1:0]];
        end
    end

    // capture the beat and hold the result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action <= t_action'(i_action);
            r_data   <= i_data_in;
            r_last   <= i_last_of_request;
        end
        if (i_cmd.execute) begin
            r_ok        <= op_ok;
            r_pull      <= pull_ok;
            r_echo      <= (push_ok || unget_ok) ? r_data : '0;
            r_occ       <= n_occ;
            r_moved_out <= n_moved;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= PW'(RESET_LEN);
            r_wp        <= '0;
            r_rp        <= '0;
            r_req_moved <= '0;
        end else if (i_cfg_wr_en) begin
            r_len       <= n_len;
            r_wp        <= '0;
            r_rp        <= '0;
            r_req_moved <= '0;
        end else if (i_cmd.execute) begin
            r_wp        <= n_w[PTR_W-1:0];
            r_rp        <= n_r[PTR_W-1:0];
            r_req_moved <= r_last ? '0 : n_moved;
        end
    end

    assign o_ok          = r_ok;
    assign o_data_out    = r_pull ? r_rdata : r_echo;
    assign o_occupancy   = r_occ;
    assign o_moved_count = r_moved_out;

endmodule
